// ----- sv/swrrh_pkg.sv -----
// Shared types, codes and helpers for the smooth weighted round-robin selector.
// No dependencies.
package swrrh_pkg;

   localparam int MAX_BACKENDS = 8;
   localparam int IDX_W        = 3;
   localparam int CNT_W        = 4;
   localparam int WGT_W        = 8;
   localparam int RW_W         = 16;
   localparam int TOT_W        = 11;
   localparam int RUN_W        = 8;
   localparam int CSR_W        = 64;
   localparam int CSR_IDX_W    = 2;

   localparam logic [1:0] ACT_PICK_HEALTHY = 2'd0;
   localparam logic [1:0] ACT_PICK_ALL     = 2'd1;
   localparam logic [1:0] ACT_REPORT       = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_ACTIVE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WEIGHTS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RECOVER = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FAIL    = 2'd3;

   typedef struct packed {
      logic                   valid;
      logic                   all;
      logic                   found;
      logic [IDX_W-1:0]       best_idx;
      logic signed [RW_W-1:0] best_val;
      logic [TOT_W-1:0]       total;
   } token_type;

   typedef struct packed {
      logic [CNT_W-1:0] count;
      logic             rpt;
      logic [IDX_W-1:0] rpt_idx;
      logic             rpt_ok;
      logic             fix;
      logic [IDX_W-1:0] fix_idx;
      logic [TOT_W-1:0] fix_total;
      logic [RUN_W-1:0] recover_thr;
      logic [RUN_W-1:0] fail_thr;
   } cell_ctl_type;

   function automatic logic signed [RW_W-1:0] sat16(input logic signed [RW_W+1:0] v);
      logic signed [RW_W+1:0] hi;
      logic signed [RW_W+1:0] lo;
      hi = 18'sd32767;
      lo = -18'sd32768;
      if (v > hi) begin
         sat16 = 16'sh7fff;
      end else if (v < lo) begin
         sat16 = 16'sh8000;
      end else begin
         sat16 = v[RW_W-1:0];
      end
   endfunction

endpackage

// ----- sv/smooth_weighted_round_robin_health.sv -----
// Top level of the smooth weighted round-robin selector with health tracking.
// Depends on swrrh_pkg and swrrh_cell (one cell per backend, chained).
//
//   port group   dir   contents
//   req_*        in    action, report_index, report_ok
//   rsp_*        out   picked, picked_index, health_changed, healthy_mask
//   csr_*        in    register writes: active_backends, weight_table, thresholds
//
// A pick registers a start token; it walks the cell chain one cell per cycle,
// then ST_FIX settles the winner's weight and ST_DONE posts the result. A
// report passes ST_RPT and ST_DONE, an unused action ST_DONE. One item is in
// work at a time; a new request is taken while the last result still waits on rsp_tready.
// Reset is synchronous: running weights and run counters clear, all healthy.
module smooth_weighted_round_robin_health #(
   parameter int BACKENDS = swrrh_pkg::MAX_BACKENDS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [7:0]                      req_tdata,  // action[1:0], report_index[4:2],
                                                       // report_ok[5]
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [15:0]                     rsp_tdata,  // picked[0], picked_index[3:1],
                                                       // health_changed[4], healthy_mask[12:5]
   input  logic                            csr_wr_en,
   input  logic [swrrh_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [swrrh_pkg::CSR_W-1:0]     csr_wdata
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WALK,
      ST_FIX,
      ST_RPT,
      ST_DONE
   } state_type;

   state_type                       state_ff, state_in;
   logic [swrrh_pkg::CNT_W-1:0]     active_ff;
   logic [swrrh_pkg::CSR_W-1:0]     weights_ff;
   logic [swrrh_pkg::RUN_W-1:0]     recover_ff;
   logic [swrrh_pkg::RUN_W-1:0]     fail_ff;

   swrrh_pkg::token_type            start_ff, start_in;
   logic                            found_ff, found_in;
   logic [swrrh_pkg::IDX_W-1:0]     best_ff, best_in;
   logic [swrrh_pkg::TOT_W-1:0]     total_ff, total_in;
   logic                            chg_ff, chg_in;
   logic [swrrh_pkg::IDX_W-1:0]     rpt_idx_ff, rpt_idx_in;
   logic                            rpt_ok_ff, rpt_ok_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [15:0]                     rsp_data_ff, rsp_data_in;

   swrrh_pkg::token_type            tok [0:BACKENDS];
   logic [BACKENDS-1:0]             healthy_v;
   logic [BACKENDS-1:0]             changed_v;
   logic [7:0]                      mask;
   logic [swrrh_pkg::CNT_W-1:0]     count;
   swrrh_pkg::cell_ctl_type         ctl;
   logic                            req_fire;
   logic [1:0]                      act;

   assign count = (active_ff > swrrh_pkg::CNT_W'(BACKENDS))
                  ? swrrh_pkg::CNT_W'(BACKENDS) : active_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff  <= '0;
         weights_ff <= '0;
         recover_ff <= 8'd2;
         fail_ff    <= 8'd3;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            swrrh_pkg::CSR_ACTIVE:  active_ff  <= csr_wdata[swrrh_pkg::CNT_W-1:0];
            swrrh_pkg::CSR_WEIGHTS: weights_ff <= csr_wdata;
            swrrh_pkg::CSR_RECOVER: recover_ff <= csr_wdata[swrrh_pkg::RUN_W-1:0];
            swrrh_pkg::CSR_FAIL:    fail_ff    <= csr_wdata[swrrh_pkg::RUN_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      ctl             = '0;
      ctl.count       = count;
      ctl.rpt         = (state_ff == ST_RPT);
      ctl.rpt_idx     = rpt_idx_ff;
      ctl.rpt_ok      = rpt_ok_ff;
      ctl.fix         = (state_ff == ST_FIX) && found_ff;
      ctl.fix_idx     = best_ff;
      ctl.fix_total   = total_ff;
      ctl.recover_thr = recover_ff;
      ctl.fail_thr    = fail_ff;
   end

   assign tok[0] = start_ff;

   for (genvar i = 0; i < BACKENDS; i++) begin : g_cell
      swrrh_cell #(
         .IDX(i)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .weight  (weights_ff[swrrh_pkg::WGT_W*i +: swrrh_pkg::WGT_W]),
         .ctl     (ctl),
         .tok_in  (tok[i]),
         .tok_out (tok[i+1]),
         .healthy (healthy_v[i]),
         .changed (changed_v[i])
      );
   end

   always_comb begin
      mask                 = '0;
      mask[BACKENDS-1:0]   = healthy_v;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign act        = req_tdata[1:0];

   always_comb begin
      state_in     = state_ff;
      start_in     = '0;
      found_in     = found_ff;
      best_in      = best_ff;
      total_in     = total_ff;
      chg_in       = chg_ff;
      rpt_idx_in   = rpt_idx_ff;
      rpt_ok_in    = rpt_ok_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               found_in   = 1'b0;
               best_in    = '0;
               total_in   = '0;
               chg_in     = 1'b0;
               rpt_idx_in = req_tdata[4:2];
               rpt_ok_in  = req_tdata[5];
               case (act)
                  swrrh_pkg::ACT_PICK_HEALTHY, swrrh_pkg::ACT_PICK_ALL: begin
                     start_in.valid = 1'b1;
                     start_in.all   = (act == swrrh_pkg::ACT_PICK_ALL);
                     state_in       = ST_WALK;
                  end
                  swrrh_pkg::ACT_REPORT: state_in = ST_RPT;
                  default:               state_in = ST_DONE;
               endcase
            end
         end
         ST_WALK: begin
            if (tok[BACKENDS].valid) begin
               found_in = tok[BACKENDS].found;
               best_in  = tok[BACKENDS].found ? tok[BACKENDS].best_idx : '0;
               total_in = tok[BACKENDS].total;
               state_in = ST_FIX;
            end
         end
         ST_FIX: begin
            state_in = ST_DONE;
         end
         ST_RPT: begin
            chg_in   = |changed_v;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {3'b000, mask, chg_ff, best_ff, found_ff};
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         start_ff.valid <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         start_ff     <= start_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      found_ff    <= found_in;
      best_ff     <= best_in;
      total_ff    <= total_in;
      chg_ff      <= chg_in;
      rpt_idx_ff  <= rpt_idx_in;
      rpt_ok_ff   <= rpt_ok_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ----- sv/swrrh_cell.sv -----
// One backend cell: running weight, health bit and outcome run counters.
// Depends on swrrh_pkg; passes the pick token on to the next cell.
module swrrh_cell #(
   parameter int IDX = 0
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [swrrh_pkg::WGT_W-1:0] weight,
   input  swrrh_pkg::cell_ctl_type     ctl,
   input  swrrh_pkg::token_type        tok_in,
   output swrrh_pkg::token_type        tok_out,
   output logic                        healthy,
   output logic                        changed
);

   logic signed [swrrh_pkg::RW_W-1:0] rw_ff, rw_in;
   logic                              healthy_ff, healthy_in;
   logic [swrrh_pkg::RUN_W-1:0]       succ_ff, succ_in;
   logic [swrrh_pkg::RUN_W-1:0]       fail_ff, fail_in;
   swrrh_pkg::token_type              tok_ff, tok_in_next;

   logic                              active;
   logic                              eligible;
   logic [swrrh_pkg::WGT_W-1:0]       w_eff;
   logic signed [swrrh_pkg::RW_W-1:0] rw_add;
   logic signed [swrrh_pkg::RW_W-1:0] rw_sub;
   logic                              rpt_hit;
   logic [swrrh_pkg::RUN_W-1:0]       succ_inc;
   logic [swrrh_pkg::RUN_W-1:0]       fail_inc;

   assign active   = swrrh_pkg::CNT_W'(IDX) < ctl.count;
   assign eligible = tok_in.valid && active && (tok_in.all || healthy_ff);
   assign w_eff    = (weight == '0) ? swrrh_pkg::WGT_W'(1) : weight;
   assign rw_add   = swrrh_pkg::sat16((swrrh_pkg::RW_W+2)'(rw_ff)
                     + $signed({{(swrrh_pkg::RW_W+2-swrrh_pkg::WGT_W){1'b0}}, w_eff}));
   assign rw_sub   = swrrh_pkg::sat16((swrrh_pkg::RW_W+2)'(rw_ff)
                     - $signed({{(swrrh_pkg::RW_W+2-swrrh_pkg::TOT_W){1'b0}}, ctl.fix_total}));
   assign rpt_hit  = ctl.rpt && active && (ctl.rpt_idx == swrrh_pkg::IDX_W'(IDX));
   assign succ_inc = (succ_ff == '1) ? succ_ff : succ_ff + 1'b1;
   assign fail_inc = (fail_ff == '1) ? fail_ff : fail_ff + 1'b1;

   always_comb begin
      rw_in       = rw_ff;
      healthy_in  = healthy_ff;
      succ_in     = succ_ff;
      fail_in     = fail_ff;
      changed     = 1'b0;
      tok_in_next = tok_in;
      if (eligible) begin
         rw_in             = rw_add;
         tok_in_next.total = tok_in.total + swrrh_pkg::TOT_W'(w_eff);
         if (!tok_in.found || (rw_add > tok_in.best_val)) begin
            tok_in_next.found    = 1'b1;
            tok_in_next.best_idx = swrrh_pkg::IDX_W'(IDX);
            tok_in_next.best_val = rw_add;
         end
      end
      if (ctl.fix && (ctl.fix_idx == swrrh_pkg::IDX_W'(IDX))) begin
         rw_in = rw_sub;
      end
      if (rpt_hit) begin
         if (ctl.rpt_ok) begin
            fail_in = '0;
            succ_in = succ_inc;
            if (!healthy_ff && (succ_inc >= ctl.recover_thr)) begin
               healthy_in = 1'b1;
               changed    = 1'b1;
            end
         end else begin
            succ_in = '0;
            fail_in = fail_inc;
            if (healthy_ff && (fail_inc >= ctl.fail_thr)) begin
               healthy_in = 1'b0;
               changed    = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rw_ff        <= '0;
         healthy_ff   <= 1'b1;
         succ_ff      <= '0;
         fail_ff      <= '0;
         tok_ff.valid <= 1'b0;
      end else begin
         rw_ff      <= rw_in;
         healthy_ff <= healthy_in;
         succ_ff    <= succ_in;
         fail_ff    <= fail_in;
         tok_ff     <= tok_in_next;
      end
   end

   assign tok_out = tok_ff;
   assign healthy = healthy_ff;

endmodule
